### sv/c8x_pkg.sv
// shared constants, opcode codes and helper functions for the instruction executor
package c8x_pkg;

    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW        = $clog2(STACK_DEPTH);
    localparam int PC_W          = 12;
    localparam int ADDR_W        = 12;
    localparam int MEM_BYTES     = 4096;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int NUM_PIXELS    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int PIX_W         = $clog2(NUM_PIXELS);
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);

    localparam logic [PC_W-1:0] START_RESET = 12'd512;

    // item kinds
    localparam logic [1:0] FUNC_EXEC = 2'd0;
    localparam logic [1:0] FUNC_MWR  = 2'd1;
    localparam logic [1:0] FUNC_MRD  = 2'd2;
    localparam logic [1:0] FUNC_PIX  = 2'd3;

    // opcode groups, top nibble
    localparam logic [3:0] OP_SYS    = 4'h0;
    localparam logic [3:0] OP_JP     = 4'h1;
    localparam logic [3:0] OP_CALL   = 4'h2;
    localparam logic [3:0] OP_SE_K   = 4'h3;
    localparam logic [3:0] OP_SNE_K  = 4'h4;
    localparam logic [3:0] OP_SE_V   = 4'h5;
    localparam logic [3:0] OP_LD_K   = 4'h6;
    localparam logic [3:0] OP_ADD_K  = 4'h7;
    localparam logic [3:0] OP_ALU    = 4'h8;
    localparam logic [3:0] OP_SNE_V  = 4'h9;
    localparam logic [3:0] OP_LD_I   = 4'hA;
    localparam logic [3:0] OP_JP_V0  = 4'hB;
    localparam logic [3:0] OP_RND    = 4'hC;
    localparam logic [3:0] OP_DRW    = 4'hD;
    localparam logic [3:0] OP_KEY    = 4'hE;
    localparam logic [3:0] OP_MISC   = 4'hF;

    localparam logic [15:0] SYS_CLS  = 16'h00E0;
    localparam logic [15:0] SYS_RET  = 16'h00EE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] MISC_GET_DT  = 8'h07;
    localparam logic [7:0] MISC_WAIT_K  = 8'h0A;
    localparam logic [7:0] MISC_SET_DT  = 8'h15;
    localparam logic [7:0] MISC_SET_ST  = 8'h18;
    localparam logic [7:0] MISC_ADD_I   = 8'h1E;
    localparam logic [7:0] MISC_FONT    = 8'h29;
    localparam logic [7:0] MISC_BCD     = 8'h33;
    localparam logic [7:0] MISC_STORE   = 8'h55;
    localparam logic [7:0] MISC_LOAD    = 8'h65;

    function automatic logic [1:0] bcd_hundreds(input logic [7:0] v);
        logic [1:0] h;
        h = 2'd0;
        if (v >= 8'd200) h = 2'd2;
        else if (v >= 8'd100) h = 2'd1;
        return h;
    endfunction

    function automatic logic [3:0] bcd_tens(input logic [6:0] v);
        logic [3:0] t;
        t = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (v >= 7'(i * 10)) t = 4'(i);
        end
        return t;
    endfunction

endpackage

### sv/c8x_ram.sv
// generic simple dual-port ram, one write port and one registered read port
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/chip8_instruction_execute_top.sv
// instruction executor top: sequencer around register, stack, memory and frame buffer rams
// throughput: one word at a time, busy is high until the result strobe
// reset: after i_rst_n the frame buffer is swept clear with busy high, then pc loads
// the start address; results are strobed for one cycle on o_done and the receiver cannot stall
module chip8_instruction_execute_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    output logic        o_done,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_opcode,
    input  logic [11:0] i_addr,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_keys,
    input  logic [7:0]  i_random_byte,
    input  logic [7:0]  i_delay_now,
    output logic [11:0] o_pc,
    output logic [15:0] o_index,
    output logic [7:0]  o_read_data,
    output logic        o_delay_load_valid,
    output logic [7:0]  o_delay_load_value,
    output logic        o_sound_load_valid,
    output logic [7:0]  o_sound_load_value,
    output logic        o_waiting_for_key,
    output logic        o_stack_fault
);

    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_CLR   = 20'h00002,
        ST_MEM   = 20'h00004,
        ST_MRD   = 20'h00008,
        ST_FETCH = 20'h00010,
        ST_VX    = 20'h00020,
        ST_VY    = 20'h00040,
        ST_WB    = 20'h00080,
        ST_RET   = 20'h00100,
        ST_BCD   = 20'h00200,
        ST_SA    = 20'h00400,
        ST_SB    = 20'h00800,
        ST_LA    = 20'h01000,
        ST_LB    = 20'h02000,
        ST_DA    = 20'h04000,
        ST_DB    = 20'h08000,
        ST_DC    = 20'h10000,
        ST_DD    = 20'h20000,
        ST_DW    = 20'h40000,
        ST_DONE  = 20'h80000
    } t_state;

    t_state r_state, n_state;
    logic   r_init, n_init;
    logic [11:0] r_start;
    logic [1:0]  r_func, n_func;
    logic [15:0] r_op, n_op;
    logic [11:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic [15:0] r_keys, n_keys;
    logic [7:0]  r_rnd, n_rnd;
    logic [7:0]  r_dnow, n_dnow;
    logic [11:0] r_pc, n_pc;
    logic [15:0] r_index, n_index;
    logic [c8x_pkg::SP_W-1:0] r_sp, n_sp;
    logic [7:0]  r_vx, n_vx;
    logic [7:0]  r_vy, n_vy;
    logic [3:0]  r_cnt, n_cnt;
    logic [2:0]  r_col, n_col;
    logic [7:0]  r_spr, n_spr;
    logic [c8x_pkg::PIX_W-1:0] r_pix, n_pix;
    logic        r_hit, n_hit;
    logic [c8x_pkg::PIX_W-1:0] r_clr, n_clr;
    logic [7:0]  r_rdata, n_rdata;
    logic        r_dv, n_dv;
    logic [7:0]  r_dval, n_dval;
    logic        r_sv, n_sv;
    logic [7:0]  r_sval, n_sval;
    logic        r_wait, n_wait;
    logic        r_fault, n_fault;
    logic [15:0] r_vvalid;
    logic        r_vrv;

    // ram ports
    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_q;
    logic        fb_we, fb_wdata, fb_q;
    logic [c8x_pkg::PIX_W-1:0] fb_waddr, fb_raddr;
    logic        stk_we;
    logic [c8x_pkg::STK_AW-1:0] stk_waddr, stk_raddr;
    logic [11:0] stk_wdata, stk_q;
    logic        v_we;
    logic [3:0]  v_waddr, v_raddr;
    logic [7:0]  v_wdata, v_q;

    c8x_ram #(.WIDTH(8), .DEPTH(c8x_pkg::MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_q)
    );

    c8x_ram #(.WIDTH(1), .DEPTH(c8x_pkg::NUM_PIXELS)) u_fb (
        .i_clk(i_clk), .i_we(fb_we), .i_waddr(fb_waddr), .i_wdata(fb_wdata),
        .i_raddr(fb_raddr), .o_rdata(fb_q)
    );

    c8x_ram #(.WIDTH(12), .DEPTH(c8x_pkg::STACK_DEPTH)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_q)
    );

    c8x_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_q)
    );

    function automatic logic [3:0] first_key(input logic [15:0] keys);
        logic [3:0] f;
        f = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (keys[k]) f = 4'(k);
        end
        return f;
    endfunction

    logic [3:0]  op_x, op_y, op_n, op_grp;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;
    logic [7:0]  vq;
    logic [8:0]  sum9;
    logic [7:0]  alu_a, alu_b, alu_res;
    logic        alu_flag, alu_fw, alu_ok;
    logic        key_dn;
    logic [1:0]  bcd_h;
    logic [7:0]  bcd_rem;
    logic [3:0]  bcd_t;
    logic [7:0]  bcd_o;
    logic [7:0]  bcd_digit;
    logic [c8x_pkg::ROW_W-1:0] pix_row;
    logic [c8x_pkg::COL_W-1:0] pix_col;
    logic [c8x_pkg::SP_W-1:0]  sp_dec;
    logic [11:0] blk_addr;
    logic [15:0] idx_blk;
    t_state      adv_state;
    logic [3:0]  adv_cnt;
    logic [2:0]  adv_col;

    assign op_grp = r_op[15:12];
    assign op_x   = r_op[11:8];
    assign op_y   = r_op[7:4];
    assign op_n   = r_op[3:0];
    assign op_kk  = r_op[7:0];
    assign op_nnn = r_op[11:0];
    // entries never written read as zero
    assign vq     = r_vrv ? v_q : 8'd0;
    assign sp_dec = r_sp - c8x_pkg::SP_W'(1);
    assign blk_addr = r_index[11:0] + 12'(r_cnt);
    assign idx_blk  = r_index + {12'd0, op_x} + 16'd1;
    assign key_dn   = (r_vx[7:4] == 4'd0) && r_keys[r_vx[3:0]];

    assign pix_row = r_vy[c8x_pkg::ROW_W-1:0] + c8x_pkg::ROW_W'(r_cnt);
    assign pix_col = r_vx[c8x_pkg::COL_W-1:0] + c8x_pkg::COL_W'(r_col);

    always_comb begin
        bcd_h   = c8x_pkg::bcd_hundreds(r_vx);
        bcd_rem = r_vx - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0));
        bcd_t   = c8x_pkg::bcd_tens(bcd_rem[6:0]);
        bcd_o   = bcd_rem - ({4'd0, bcd_t} << 3) - ({4'd0, bcd_t} << 1);
        case (r_cnt[1:0])
            2'd0:    bcd_digit = {6'd0, bcd_h};
            2'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = bcd_o;
        endcase
    end

    // alu on vx and vy, flag written after the destination
    always_comb begin
        alu_a    = r_vx;
        alu_b    = vq;
        sum9     = {1'b0, alu_a} + {1'b0, alu_b};
        alu_res  = alu_a;
        alu_flag = 1'b0;
        alu_fw   = 1'b0;
        alu_ok   = 1'b1;
        unique case (op_n)
            c8x_pkg::ALU_MOV: alu_res = alu_b;
            c8x_pkg::ALU_OR:  alu_res = alu_a | alu_b;
            c8x_pkg::ALU_AND: alu_res = alu_a & alu_b;
            c8x_pkg::ALU_XOR: alu_res = alu_a ^ alu_b;
            c8x_pkg::ALU_ADD: begin
                alu_flag = sum9[8];
                alu_res  = sum9[7:0];
                alu_fw   = 1'b1;
            end
            c8x_pkg::ALU_SUB: begin
                // operands read again after the flag write
                alu_flag = (alu_a >= alu_b);
                alu_res  = ((op_x == 4'hF) ? {7'd0, alu_flag} : alu_a)
                         - ((op_y == 4'hF) ? {7'd0, alu_flag} : alu_b);
                alu_fw   = 1'b1;
            end
            c8x_pkg::ALU_SHR: begin
                alu_flag = alu_a[0];
                alu_res  = {1'b0, alu_a[7:1]};
                alu_fw   = 1'b1;
            end
            c8x_pkg::ALU_SUBN: begin
                alu_flag = (alu_b >= alu_a);
                alu_res  = alu_b - alu_a;
                alu_fw   = 1'b1;
            end
            c8x_pkg::ALU_SHL: begin
                alu_flag = alu_a[7];
                alu_res  = {alu_a[6:0], 1'b0};
                alu_fw   = 1'b1;
            end
            default: alu_ok = 1'b0;
        endcase
    end

    // next sprite pixel, row or end of draw
    always_comb begin
        adv_state = ST_DC;
        adv_cnt   = r_cnt;
        adv_col   = r_col + 3'd1;
        if (r_col == 3'd7) begin
            adv_col = 3'd0;
            if (r_cnt == op_n - 4'd1) begin
                adv_state = ST_DW;
            end else begin
                adv_cnt   = r_cnt + 4'd1;
                adv_state = ST_DA;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        n_func  = r_func;
        n_op    = r_op;
        n_addr  = r_addr;
        n_data  = r_data;
        n_keys  = r_keys;
        n_rnd   = r_rnd;
        n_dnow  = r_dnow;
        n_pc    = r_pc;
        n_index = r_index;
        n_sp    = r_sp;
        n_vx    = r_vx;
        n_vy    = r_vy;
        n_cnt   = r_cnt;
        n_col   = r_col;
        n_spr   = r_spr;
        n_pix   = r_pix;
        n_hit   = r_hit;
        n_clr   = r_clr;
        n_rdata = r_rdata;
        n_dv    = r_dv;
        n_dval  = r_dval;
        n_sv    = r_sv;
        n_sval  = r_sval;
        n_wait  = r_wait;
        n_fault = r_fault;

        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_data;
        mem_raddr = r_addr;
        fb_we     = 1'b0;
        fb_waddr  = r_pix;
        fb_wdata  = 1'b0;
        fb_raddr  = r_pix;
        stk_we    = 1'b0;
        stk_waddr = r_sp[c8x_pkg::STK_AW-1:0];
        stk_wdata = r_pc;
        stk_raddr = sp_dec[c8x_pkg::STK_AW-1:0];
        v_we      = 1'b0;
        v_waddr   = op_x;
        v_wdata   = alu_res;
        v_raddr   = op_x;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_func  = i_func;
                    n_op    = i_opcode;
                    n_addr  = i_addr;
                    n_data  = i_data;
                    n_keys  = i_keys;
                    n_rnd   = i_random_byte;
                    n_dnow  = i_delay_now;
                    n_rdata = 8'd0;
                    n_dv    = 1'b0;
                    n_dval  = 8'd0;
                    n_sv    = 1'b0;
                    n_sval  = 8'd0;
                    n_wait  = 1'b0;
                    n_fault = 1'b0;
                    n_state = (i_func == c8x_pkg::FUNC_EXEC) ? ST_FETCH : ST_MEM;
                end
            end
            ST_CLR: begin
                fb_we    = 1'b1;
                fb_waddr = r_clr;
                n_clr    = r_clr + c8x_pkg::PIX_W'(1);
                if (r_clr == c8x_pkg::PIX_W'(c8x_pkg::NUM_PIXELS - 1)) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_pc    = r_start;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MEM: begin
                n_state = ST_MRD;
                unique case (r_func)
                    c8x_pkg::FUNC_MWR: begin
                        mem_we  = 1'b1;
                        n_state = ST_DONE;
                    end
                    c8x_pkg::FUNC_PIX: fb_raddr = r_addr[c8x_pkg::PIX_W-1:0];
                    default: mem_raddr = r_addr;
                endcase
            end
            ST_MRD: begin
                if (r_func == c8x_pkg::FUNC_MRD) begin
                    n_rdata = mem_q;
                end else if (r_addr < 12'(c8x_pkg::NUM_PIXELS)) begin
                    n_rdata = {7'd0, fb_q};
                end
                n_state = ST_DONE;
            end
            ST_FETCH: begin
                n_pc    = r_pc + 12'd2;
                v_raddr = (op_grp == c8x_pkg::OP_JP_V0) ? 4'd0 : op_x;
                n_state = ST_VX;
            end
            ST_VX: begin
                n_vx    = vq;
                v_raddr = op_y;
                n_state = ST_VY;
            end
            ST_VY: begin
                n_vy    = vq;
                n_state = ST_DONE;
                unique case (op_grp)
                    c8x_pkg::OP_SYS: begin
                        if (r_op == c8x_pkg::SYS_CLS) begin
                            n_clr   = '0;
                            n_state = ST_CLR;
                        end else if (r_op == c8x_pkg::SYS_RET) begin
                            if (r_sp == '0) begin
                                n_fault = 1'b1;
                            end else begin
                                n_sp    = sp_dec;
                                n_state = ST_RET;
                            end
                        end
                    end
                    c8x_pkg::OP_JP: n_pc = op_nnn;
                    c8x_pkg::OP_CALL: begin
                        if (r_sp >= c8x_pkg::SP_W'(c8x_pkg::STACK_DEPTH)) begin
                            n_fault = 1'b1;
                        end else begin
                            stk_we = 1'b1;
                            n_sp   = r_sp + c8x_pkg::SP_W'(1);
                            n_pc   = op_nnn;
                        end
                    end
                    c8x_pkg::OP_SE_K:  if (r_vx == op_kk) n_pc = r_pc + 12'd2;
                    c8x_pkg::OP_SNE_K: if (r_vx != op_kk) n_pc = r_pc + 12'd2;
                    c8x_pkg::OP_SE_V:  if (r_vx == vq) n_pc = r_pc + 12'd2;
                    c8x_pkg::OP_SNE_V: if (r_vx != vq) n_pc = r_pc + 12'd2;
                    c8x_pkg::OP_LD_K: begin
                        v_we    = 1'b1;
                        v_wdata = op_kk;
                    end
                    c8x_pkg::OP_ADD_K: begin
                        v_we    = 1'b1;
                        v_wdata = r_vx + op_kk;
                    end
                    c8x_pkg::OP_ALU: begin
                        v_we  = alu_ok;
                        n_hit = alu_flag;
                        // flag survives only when the destination is not vf
                        if (alu_ok && alu_fw && op_x != 4'hF) n_state = ST_WB;
                    end
                    c8x_pkg::OP_LD_I:  n_index = {4'd0, op_nnn};
                    c8x_pkg::OP_JP_V0: n_pc = op_nnn + {4'd0, r_vx};
                    c8x_pkg::OP_RND: begin
                        v_we    = 1'b1;
                        v_wdata = r_rnd & op_kk;
                    end
                    c8x_pkg::OP_DRW: begin
                        n_hit   = 1'b0;
                        n_cnt   = 4'd0;
                        n_state = (op_n == 4'd0) ? ST_DW : ST_DA;
                    end
                    c8x_pkg::OP_KEY: begin
                        if (op_kk == c8x_pkg::KEY_SKP && key_dn) n_pc = r_pc + 12'd2;
                        if (op_kk == c8x_pkg::KEY_SKNP && !key_dn) n_pc = r_pc + 12'd2;
                    end
                    default: begin
                        unique case (op_kk)
                            c8x_pkg::MISC_GET_DT: begin
                                v_we    = 1'b1;
                                v_wdata = r_dnow;
                            end
                            c8x_pkg::MISC_WAIT_K: begin
                                if (r_keys == 16'd0) begin
                                    n_pc   = r_pc - 12'd2;
                                    n_wait = 1'b1;
                                end else begin
                                    v_we    = 1'b1;
                                    v_wdata = {4'd0, first_key(r_keys)};
                                end
                            end
                            c8x_pkg::MISC_SET_DT: begin
                                n_dv   = 1'b1;
                                n_dval = r_vx;
                            end
                            c8x_pkg::MISC_SET_ST: begin
                                n_sv   = 1'b1;
                                n_sval = r_vx;
                            end
                            c8x_pkg::MISC_ADD_I: n_index = r_index + {8'd0, r_vx};
                            c8x_pkg::MISC_FONT:
                                n_index = {6'd0, r_vx, 2'd0} + {8'd0, r_vx};
                            c8x_pkg::MISC_BCD: begin
                                n_cnt   = 4'd0;
                                n_state = ST_BCD;
                            end
                            c8x_pkg::MISC_STORE: begin
                                n_cnt   = 4'd0;
                                n_state = ST_SA;
                            end
                            c8x_pkg::MISC_LOAD: begin
                                n_cnt   = 4'd0;
                                n_state = ST_LA;
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            ST_WB: begin
                v_we    = 1'b1;
                v_waddr = 4'hF;
                v_wdata = {7'd0, r_hit};
                n_state = ST_DONE;
            end
            ST_RET: begin
                n_pc    = stk_q;
                n_state = ST_DONE;
            end
            ST_BCD: begin
                mem_we    = 1'b1;
                mem_waddr = blk_addr;
                mem_wdata = bcd_digit;
                n_cnt     = r_cnt + 4'd1;
                if (r_cnt == 4'd2) n_state = ST_DONE;
            end
            ST_SA: begin
                v_raddr = r_cnt;
                n_state = ST_SB;
            end
            ST_SB: begin
                mem_we    = 1'b1;
                mem_waddr = blk_addr;
                mem_wdata = vq;
                n_cnt     = r_cnt + 4'd1;
                if (r_cnt == op_x) begin
                    n_index = idx_blk;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SA;
                end
            end
            ST_LA: begin
                mem_raddr = blk_addr;
                n_state   = ST_LB;
            end
            ST_LB: begin
                v_we    = 1'b1;
                v_waddr = r_cnt;
                v_wdata = mem_q;
                n_cnt   = r_cnt + 4'd1;
                if (r_cnt == op_x) begin
                    n_index = idx_blk;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_LA;
                end
            end
            ST_DA: begin
                mem_raddr = blk_addr;
                n_state   = ST_DB;
            end
            ST_DB: begin
                n_spr   = mem_q;
                n_col   = 3'd0;
                n_state = ST_DC;
            end
            ST_DC: begin
                n_pix    = {pix_row, pix_col};
                fb_raddr = {pix_row, pix_col};
                if (r_spr[3'd7 - r_col]) begin
                    n_state = ST_DD;
                end else begin
                    n_state = adv_state;
                    n_cnt   = adv_cnt;
                    n_col   = adv_col;
                end
            end
            ST_DD: begin
                // toggle the pixel, a lit pixel turned off is a collision
                if (fb_q) n_hit = 1'b1;
                fb_we    = 1'b1;
                fb_wdata = ~fb_q;
                n_state  = adv_state;
                n_cnt    = adv_cnt;
                n_col    = adv_col;
            end
            ST_DW: begin
                v_we    = 1'b1;
                v_waddr = 4'hF;
                v_wdata = {7'd0, r_hit};
                n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_init   <= 1'b1;
            r_start  <= c8x_pkg::START_RESET;
            r_pc     <= c8x_pkg::START_RESET;
            r_index  <= 16'd0;
            r_sp     <= '0;
            r_clr    <= '0;
            r_vvalid <= 16'd0;
            r_vrv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            if (i_cfg_we) r_start <= i_cfg_wdata;
            r_pc    <= n_pc;
            r_index <= n_index;
            r_sp    <= n_sp;
            r_clr   <= n_clr;
            if (v_we) r_vvalid[v_waddr] <= 1'b1;
            r_vrv   <= r_vvalid[v_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_op    <= n_op;
        r_addr  <= n_addr;
        r_data  <= n_data;
        r_keys  <= n_keys;
        r_rnd   <= n_rnd;
        r_dnow  <= n_dnow;
        r_vx    <= n_vx;
        r_vy    <= n_vy;
        r_cnt   <= n_cnt;
        r_col   <= n_col;
        r_spr   <= n_spr;
        r_pix   <= n_pix;
        r_hit   <= n_hit;
        r_rdata <= n_rdata;
        r_dv    <= n_dv;
        r_dval  <= n_dval;
        r_sv    <= n_sv;
        r_sval  <= n_sval;
        r_wait  <= n_wait;
        r_fault <= n_fault;
    end

    assign busy               = (r_state != ST_IDLE);
    assign o_done             = (r_state == ST_DONE);
    assign o_pc               = r_pc;
    assign o_index            = r_index;
    assign o_read_data        = r_rdata;
    assign o_delay_load_valid = r_dv;
    assign o_delay_load_value = r_dval;
    assign o_sound_load_valid = r_sv;
    assign o_sound_load_value = r_sval;
    assign o_waiting_for_key  = r_wait;
    assign o_stack_fault      = r_fault;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= c8x_pkg::SP_W'(c8x_pkg::STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_timer_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_delay_load_valid && o_sound_load_valid))
        else $error("both timer loads in one result");

endmodule
